[design/pda_pkg.sv]
// Shared types, constants and defaults for the Poisson deviance accumulator.
// No dependencies; every other file refers to it by scoped names.
package pda_pkg;

  // Parameter defaults
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // Fixed field widths
  localparam int unsigned EXPECT_W = 32;
  localparam int unsigned STAT_W   = 48;
  localparam int unsigned TOTAL_W  = 56;
  localparam int unsigned LEAD_W   = 5;
  localparam int unsigned MANT_W   = 31;   // Q1.30 mantissa
  localparam int unsigned MUL_W    = 32;
  localparam int unsigned PROD_W   = 2 * MUL_W;

  localparam logic [STAT_W-1:0]  STAT_MAX  = {STAT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [MUL_W-1:0]   LN2_Q32   = 32'd2977044472;
  localparam logic [PROD_W-1:0]  ROUND_HALF = 64'h0000_0000_8000_0000;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM_D,
    ST_SQ_D,
    ST_NORM_M,
    ST_SQ_M,
    ST_DIFF,
    ST_LN,
    ST_RND,
    ST_TERM,
    ST_SUM,
    ST_DONE
  } state_e;

  // Normaliser result back to the sequencer
  typedef struct packed {
    logic              done;
    logic [LEAD_W-1:0] lead_pos;
    logic [MANT_W-1:0] mant;
  } norm_res_t;

endpackage

[design/pda_in_if.sv]
// Request channel for one histogram bin: valid/ready with the bin payload.
// Depends on pda_pkg for widths and defaults.
interface pda_in_if #(
  parameter int unsigned COUNT_WIDTH = pda_pkg::COUNT_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [pda_pkg::EXPECT_W-1:0]  model_expect;
  logic [COUNT_WIDTH-1:0]        data_count;
  logic                          last_bin;

  modport source (output valid, model_expect, data_count, last_bin, input ready);
  modport sink   (input valid, model_expect, data_count, last_bin, output ready);
endinterface

[design/pda_out_if.sv]
// Result channel: valid/ready with the bin statistic and running total.
// Depends on pda_pkg for widths.
interface pda_out_if;
  logic                         valid;
  logic                         ready;
  logic [pda_pkg::STAT_W-1:0]   bin_stat;
  logic [pda_pkg::TOTAL_W-1:0]  running_total;
  logic                         overflow_flag;
  logic                         is_last;

  modport source (output valid, bin_stat, running_total, overflow_flag, is_last, input ready);
  modport sink   (input valid, bin_stat, running_total, overflow_flag, is_last, output ready);
endinterface

[design/pda_norm.sv]
// Leading-one normaliser: binary search over a 32-bit word in five steps.
// Depends on pda_pkg for the result struct and widths.
module pda_norm (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [pda_pkg::EXPECT_W-1:0]      x_i,
  output pda_pkg::norm_res_t                res_o
);

  localparam logic [2:0] LAST_STEP = 3'd4;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [2:0]                    step_q, step_d;
  logic [pda_pkg::EXPECT_W-1:0]  x_q, x_d;
  logic [pda_pkg::LEAD_W-1:0]    lead_q, lead_d;
  logic [pda_pkg::LEAD_W-1:0]    sh;
  logic                          hi_zero;

  always_comb begin
    sh      = 5'(5'd16 >> step_q);
    hi_zero = ((x_q >> (6'd32 - 6'(sh))) == '0);
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    x_d     = x_q;
    lead_d  = lead_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      x_d    = x_i;
      lead_d = 5'd31;
    end else if (busy_q) begin
      // shift the top half out while it holds no one
      if (hi_zero) begin
        x_d    = x_q << sh;
        lead_d = lead_q - sh;
      end
      step_d = step_q + 3'd1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    lead_q <= lead_d;
  end

  assign res_o.done     = done_q;
  assign res_o.lead_pos = lead_q;
  assign res_o.mant     = x_q[pda_pkg::EXPECT_W-1:1];

endmodule

[design/poisson_deviance_accumulator.sv]
// Poisson deviance accumulator: per-bin saturated Poisson statistic and running total.
// Depends on pda_pkg, pda_in_if, pda_out_if and pda_norm.
//
// Each request is one histogram bin (expectation nM in Q16.16, count nD). The block
// returns 2*(nM - nD + nD*ln(nD/nM)) in Q32.16, saturating, and a saturating running
// total that clears after a bin marked last, together with a sticky overflow flag for
// the pass. A bin with nonzero count and nonzero expectation computes two base-2
// logarithms, each by a leading-one search and then mantissa squaring on the single
// 32x32 multiplier, which then also scales by ln2 and by the count. A bin with zero
// count or zero expectation skips the logarithms. A new request is taken while a
// finished result still waits on the output register.
module poisson_deviance_accumulator #(
  parameter int unsigned COUNT_WIDTH = pda_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = pda_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pda_in_if.sink        in_i,
  pda_out_if.source     out_o
);

  localparam int unsigned LOG_W  = pda_pkg::LEAD_W + FRAC_BITS; // log2 value
  localparam int unsigned DIFF_W = FRAC_BITS + 7;                // signed log difference
  localparam int unsigned MAG_W  = FRAC_BITS + 6;                // its magnitude
  localparam int unsigned S_W    = 65;                           // signed term
  localparam int unsigned ITER_W = $clog2(FRAC_BITS);
  localparam int unsigned TSUM_W = pda_pkg::TOTAL_W + 1;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(FRAC_BITS - 1);
  localparam logic [DIFF_W-1:0] FRAC_OFS  = DIFF_W'(FRAC_BITS << FRAC_BITS);

  pda_pkg::state_e state_q, state_d;

  // Request latch
  logic [pda_pkg::EXPECT_W-1:0] nm_q;
  logic [COUNT_WIDTH-1:0]       nd_q;
  logic                         last_q;

  // Logarithm iteration
  logic [pda_pkg::MANT_W-1:0]   mant_q;
  logic [FRAC_BITS-1:0]         frac_q;
  logic [pda_pkg::LEAD_W-1:0]   lead_q;
  logic [ITER_W-1:0]            iter_q, iter_d;
  logic [LOG_W-1:0]             logd_q, logm_q;

  // Scaling and term
  logic                         neg_q;
  logic [MAG_W-1:0]             mag_q, lnmag_q;
  logic signed [S_W-1:0]        base_q;
  logic [pda_pkg::PROD_W-1:0]   prod_q;
  logic [pda_pkg::STAT_W-1:0]   stat_q;
  logic                         stat_flag_q;

  // Pass state and output register
  logic [pda_pkg::TOTAL_W-1:0]  acc_q, acc_d;
  logic                         sticky_q, sticky_d;
  logic                         out_valid_q, out_valid_d;
  logic [pda_pkg::STAT_W-1:0]   out_stat_q;
  logic [pda_pkg::TOTAL_W-1:0]  out_total_q;
  logic                         out_ovf_q;
  logic                         out_last_q;

  // Shared multiplier
  logic [pda_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic [pda_pkg::PROD_W-1:0]   prod;

  // Normaliser
  logic                         norm_start;
  logic [pda_pkg::EXPECT_W-1:0] norm_x;
  pda_pkg::norm_res_t           norm_res;

  // Control
  logic                         in_fire;
  logic                         out_load;
  logic                         sq_hi;
  logic [pda_pkg::MANT_W-1:0]   mant_sq;
  logic [FRAC_BITS-1:0]         frac_next;
  logic signed [DIFF_W-1:0]     diff;
  logic signed [S_W-1:0]        term;
  logic [TSUM_W-1:0]            tsum;
  logic [pda_pkg::TOTAL_W-1:0]  total_sat;
  logic                         bin_flag;

  assign in_i.ready = (state_q == pda_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == pda_pkg::ST_DONE) && (!out_valid_q || out_o.ready);

  pda_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .x_i     (norm_x),
    .res_o   (norm_res)
  );

  // Operand select for the one multiplier
  always_comb begin
    unique case (state_q)
      pda_pkg::ST_SQ_D, pda_pkg::ST_SQ_M: begin
        mul_a = pda_pkg::MUL_W'(mant_q);
        mul_b = pda_pkg::MUL_W'(mant_q);
      end
      pda_pkg::ST_LN: begin
        mul_a = pda_pkg::MUL_W'(mag_q);
        mul_b = pda_pkg::LN2_Q32;
      end
      pda_pkg::ST_TERM: begin
        mul_a = pda_pkg::MUL_W'(nd_q);
        mul_b = pda_pkg::MUL_W'(lnmag_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = pda_pkg::PROD_W'(mul_a) * pda_pkg::PROD_W'(mul_b);

  // One squaring step: square, drop 30 bits, renormalise by one if it reached two
  assign sq_hi     = prod[61];
  assign mant_sq   = sq_hi ? prod[61:31] : prod[60:30];
  assign frac_next = {frac_q[FRAC_BITS-2:0], sq_hi};

  assign diff = $signed(DIFF_W'(logd_q) + FRAC_OFS - DIFF_W'(logm_q));
  assign term = neg_q ? (base_q - $signed(S_W'(prod_q))) : (base_q + $signed(S_W'(prod_q)));

  // Total with saturation
  assign tsum      = TSUM_W'(acc_q) + TSUM_W'(stat_q);
  assign total_sat = tsum[TSUM_W-1] ? pda_pkg::TOTAL_MAX : tsum[pda_pkg::TOTAL_W-1:0];
  assign bin_flag  = stat_flag_q || tsum[TSUM_W-1];

  // Sequencer: next state and unit control
  always_comb begin
    state_d    = state_q;
    iter_d     = iter_q;
    norm_start = 1'b0;
    norm_x     = nm_q;
    unique case (state_q)
      pda_pkg::ST_IDLE: begin
        norm_x = pda_pkg::EXPECT_W'(in_i.data_count);
        if (in_fire) begin
          // zero count or zero expectation need no logarithm
          if ((in_i.data_count == '0) || (in_i.model_expect == '0)) begin
            state_d = pda_pkg::ST_DONE;
          end else begin
            norm_start = 1'b1;
            state_d    = pda_pkg::ST_NORM_D;
          end
        end
      end
      pda_pkg::ST_NORM_D: begin
        iter_d = '0;
        if (norm_res.done) state_d = pda_pkg::ST_SQ_D;
      end
      pda_pkg::ST_SQ_D: begin
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_LAST) begin
          norm_start = 1'b1;
          state_d    = pda_pkg::ST_NORM_M;
        end
      end
      pda_pkg::ST_NORM_M: begin
        iter_d = '0;
        if (norm_res.done) state_d = pda_pkg::ST_SQ_M;
      end
      pda_pkg::ST_SQ_M: begin
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_LAST) state_d = pda_pkg::ST_DIFF;
      end
      pda_pkg::ST_DIFF: state_d = pda_pkg::ST_LN;
      pda_pkg::ST_LN:   state_d = pda_pkg::ST_RND;
      pda_pkg::ST_RND:  state_d = pda_pkg::ST_TERM;
      pda_pkg::ST_TERM: state_d = pda_pkg::ST_SUM;
      pda_pkg::ST_SUM:  state_d = pda_pkg::ST_DONE;
      pda_pkg::ST_DONE: begin
        if (out_load) state_d = pda_pkg::ST_IDLE;
      end
      default: state_d = pda_pkg::ST_IDLE;
    endcase
  end

  // Pass state and output handshake
  always_comb begin
    acc_d       = acc_q;
    sticky_d    = sticky_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (out_load) begin
      out_valid_d = 1'b1;
      // clear the pass after the last bin is reported
      acc_d    = last_q ? '0 : total_sat;
      sticky_d = last_q ? 1'b0 : (sticky_q || bin_flag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pda_pkg::ST_IDLE;
      iter_q      <= '0;
      acc_q       <= '0;
      sticky_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      acc_q       <= acc_d;
      sticky_q    <= sticky_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pda_pkg::ST_IDLE: begin
        if (in_fire) begin
          nm_q   <= in_i.model_expect;
          nd_q   <= in_i.data_count;
          last_q <= in_i.last_bin;
          if (in_i.data_count == '0) begin
            stat_q      <= pda_pkg::STAT_W'(in_i.model_expect) << 1;
            stat_flag_q <= 1'b0;
          end else begin
            // zero expectation saturates; other bins overwrite this later
            stat_q      <= pda_pkg::STAT_MAX;
            stat_flag_q <= 1'b1;
          end
        end
      end
      pda_pkg::ST_NORM_D, pda_pkg::ST_NORM_M: begin
        mant_q <= norm_res.mant;
        lead_q <= norm_res.lead_pos;
        frac_q <= '0;
      end
      pda_pkg::ST_SQ_D: begin
        mant_q <= mant_sq;
        frac_q <= frac_next;
        if (iter_q == ITER_LAST) logd_q <= {lead_q, frac_next};
      end
      pda_pkg::ST_SQ_M: begin
        mant_q <= mant_sq;
        frac_q <= frac_next;
        if (iter_q == ITER_LAST) logm_q <= {lead_q, frac_next};
      end
      pda_pkg::ST_DIFF: begin
        neg_q  <= diff[DIFF_W-1];
        mag_q  <= diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        base_q <= $signed(S_W'(nm_q)) - $signed(S_W'(nd_q) << FRAC_BITS);
      end
      pda_pkg::ST_LN: prod_q <= prod;
      pda_pkg::ST_RND: lnmag_q <= MAG_W'((prod_q + pda_pkg::ROUND_HALF) >> 32);
      pda_pkg::ST_TERM: prod_q <= prod;
      pda_pkg::ST_SUM: begin
        // clamp negative rounding to zero, saturate a large term
        if (term[S_W-1] || (term == '0)) begin
          stat_q      <= '0;
          stat_flag_q <= 1'b0;
        end else if (term[S_W-2:pda_pkg::STAT_W-1] != '0) begin
          stat_q      <= pda_pkg::STAT_MAX;
          stat_flag_q <= 1'b1;
        end else begin
          stat_q      <= {term[pda_pkg::STAT_W-2:0], 1'b0};
          stat_flag_q <= 1'b0;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_stat_q  <= stat_q;
      out_total_q <= total_sat;
      out_ovf_q   <= sticky_q || bin_flag;
      out_last_q  <= last_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.bin_stat      = out_stat_q;
  assign out_o.running_total = out_total_q;
  assign out_o.overflow_flag = out_ovf_q;
  assign out_o.is_last       = out_last_q;

  // A zero-count request skips straight to the result stage
  a_zero_count_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.data_count == '0) |=> state_q == pda_pkg::ST_DONE)
    else $error("zero-count request did not skip the logarithm");

  // Only a flagged bin may carry the all-ones statistic
  a_max_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_stat_q == pda_pkg::STAT_MAX) |-> out_ovf_q)
    else $error("saturated statistic without overflow flag");

  // The running total never falls below the bin it includes
  a_total_covers_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_total_q >= pda_pkg::TOTAL_W'(out_stat_q))
    else $error("running total below bin statistic");

  // The normaliser finishes only while the sequencer waits for it
  a_norm_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_res.done |-> (state_q == pda_pkg::ST_NORM_D) || (state_q == pda_pkg::ST_NORM_M))
    else $error("normaliser result outside a normalise state");

endmodule
